[rtl/tcc_pkg.sv]
// Shared types and constants for the touch coordinate calibrator.
// Used by tcc_div and touch_coordinate_calibrator_top; no dependencies.
package tcc_pkg;

  // Field and register widths
  localparam int RAW_W    = 13;
  localparam int COORD_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int RAW_DROP = 3;

  // Low ends of the screen ranges
  localparam int SCREEN_MIN_X = 0;
  localparam int SCREEN_MIN_Y = 0;

  // Divider sizing: magnitude of (raw - lo) * span over magnitude of (hi - lo)
  localparam int MAG_W   = RAW_W;
  localparam int DVD_W   = 2 * MAG_W;
  localparam int DVS_W   = MAG_W;
  localparam int DIV_ITER = DVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // Mode flag bit positions
  localparam int MODE_MIRROR_X = 0;
  localparam int MODE_MIRROR_Y = 1;
  localparam int MODE_PAIR     = 2;
  localparam int MODE_SWAP     = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_LOW_X    = 3'd0,
    REG_RAW_HIGH_X   = 3'd1,
    REG_RAW_LOW_Y    = 3'd2,
    REG_RAW_HIGH_Y   = 3'd3,
    REG_SCREEN_MAX_X = 3'd4,
    REG_SCREEN_MAX_Y = 3'd5,
    REG_MODE_FLAGS   = 3'd6
  } tcc_reg_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } tcc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } tcc_div_rsp_t;

endpackage

[rtl/tcc_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on tcc_pkg for widths and the request/response structs.
module tcc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcc_pkg::tcc_div_req_t req,
  output tcc_pkg::tcc_div_rsp_t rsp
);
  import tcc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVD_W-1:0]     quo_r;

  logic [DVS_W:0]   t1, t2;
  logic [DVS_W-1:0] r1, r2;
  logic             b1, b2;

  // Two dependent shift-compare-subtract steps
  always_comb begin
    t1 = {rem_r, quo_r[DVD_W-1]};
    b1 = (t1 >= {1'b0, dvs_r});
    r1 = b1 ? DVS_W'(t1 - {1'b0, dvs_r}) : t1[DVS_W-1:0];
    t2 = {r1, quo_r[DVD_W-2]};
    b2 = (t2 >= {1'b0, dvs_r});
    r2 = b2 ? DVS_W'(t2 - {1'b0, dvs_r}) : t2[DVS_W-1:0];
  end

  // Load on start, iterate while busy, pulse done after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        quo_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= r2;
        quo_r <= {quo_r[DVD_W-3:0], b1, b2};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a finished run");
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r < DIV_CNT_W'(DIV_ITER)))
    else $error("divider step count out of range");
`endif

endmodule

[rtl/touch_coordinate_calibrator_top.sv]
// One item is in work at a time; the next is accepted once the last has finished.
// Each item goes through the serial divider, which makes two quotient bits per cycle.
// The input is stalled while an item is in work; a finished result waits in an
// output register, and the last step waits only if that register is still held.
// Synchronous active-low reset restores calibration registers and clears pair state.
// Depends on tcc_pkg and tcc_div.
module touch_coordinate_calibrator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_channel,
  input  logic [tcc_pkg::BYTE_W-1:0]     in_high_byte,
  input  logic [tcc_pkg::BYTE_W-1:0]     in_low_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_axis,
  output logic [tcc_pkg::COORD_W-1:0]    out_coordinate,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcc_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_WAIT,
    S_FIN
  } state_t;

  localparam int V_W = DVD_W + 2;

  // Configuration registers
  logic [RAW_W-1:0]   raw_low_x_r, raw_high_x_r, raw_low_y_r, raw_high_y_r;
  logic [COORD_W-1:0] screen_max_x_r, screen_max_y_r;
  logic [MODE_W-1:0]  mode_r;

  // Sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic               ch_r;
  logic [RAW_W-1:0]   raw_r;
  logic [MAG_W-1:0]   mag_raw_r, mag_span_r, mag_den_r;
  logic               neg_r, den_zero_r;
  logic [1:0]         pend_r;
  logic [COORD_W-1:0] first_r [2];
  logic               out_valid_r, out_axis_r;
  logic [COORD_W-1:0] out_coord_r;

  tcc_div_req_t div_req;
  tcc_div_rsp_t div_rsp;

  // Per-channel calibration selection
  logic [RAW_W-1:0]       lo_sel, hi_sel;
  logic [COORD_W-1:0]     omax_sel;
  logic signed [RAW_W:0]  d_raw, d_den;
  logic signed [RAW_W-1:0] d_span;
  logic signed [V_W-1:0]  omin_v, omax_v, q_s, v_lin, v_mir;
  logic                   mirror, gate, pair_mode, emit, advance;
  logic [COORD_W-1:0]     val;

  always_comb begin
    lo_sel   = ch_r ? raw_low_y_r  : raw_low_x_r;
    hi_sel   = ch_r ? raw_high_y_r : raw_high_x_r;
    omax_sel = ch_r ? screen_max_y_r : screen_max_x_r;
    omin_v   = ch_r ? V_W'(SCREEN_MIN_Y) : V_W'(SCREEN_MIN_X);
    omax_v   = $signed({{(V_W-COORD_W){1'b0}}, omax_sel});
    mirror   = ch_r ? mode_r[MODE_MIRROR_Y] : mode_r[MODE_MIRROR_X];
    d_raw    = $signed({1'b0, raw_r}) - $signed({1'b0, lo_sel});
    d_den    = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
    d_span   = $signed({1'b0, omax_sel}) - $signed(RAW_W'(omin_v));
  end

  // Sign, offset, mirror and gate the quotient
  always_comb begin
    q_s   = neg_r ? -$signed({2'b00, div_rsp.quotient})
                  :  $signed({2'b00, div_rsp.quotient});
    v_lin = q_s + omin_v;
    v_mir = mirror ? (omax_v - v_lin) : v_lin;
    gate  = !den_zero_r && (v_mir > omin_v) && (v_mir < omax_v);
    val   = gate ? v_mir[COORD_W-1:0] : '0;
    pair_mode = mode_r[MODE_PAIR];
    emit    = !pair_mode || (pend_r[ch_r] && (first_r[ch_r] == val));
    advance = !emit || !out_valid_r || !out_stall;
  end

  // Divider request: the product is registered inside the divider
  always_comb begin
    div_req.start    = (state_r == S_MUL);
    div_req.dividend = DVD_W'(mag_raw_r * mag_span_r);
    div_req.divisor  = mag_den_r;
  end

  tcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PREP;
      S_PREP: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_WAIT;
      S_WAIT: if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:  if (advance) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, datapath, pair state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // drop the result once taken
      if (out_valid_r && !out_stall && !(state_r == S_FIN && advance && emit))
        out_valid_r <= 1'b0;
      // capture a transaction
      if (state_r == S_IDLE && in_valid) begin
        ch_r  <= in_channel;
        raw_r <= {in_high_byte, in_low_byte[BYTE_W-1:RAW_DROP]};
      end
      // take magnitudes and the quotient sign
      if (state_r == S_PREP) begin
        mag_raw_r  <= d_raw[RAW_W]  ? MAG_W'(-d_raw) : MAG_W'(d_raw);
        mag_den_r  <= d_den[RAW_W]  ? MAG_W'(-d_den) : MAG_W'(d_den);
        mag_span_r <= d_span[RAW_W-1] ? MAG_W'(-d_span) : MAG_W'(d_span);
        neg_r      <= d_raw[RAW_W] ^ d_den[RAW_W] ^ d_span[RAW_W-1];
        den_zero_r <= (d_den == '0);
      end
      // finish: pair bookkeeping and result
      if (state_r == S_FIN && advance) begin
        if (pair_mode) begin
          if (!pend_r[ch_r]) begin
            first_r[ch_r] <= val;
            pend_r[ch_r]  <= 1'b1;
          end else begin
            pend_r[ch_r] <= 1'b0;
          end
        end
        if (emit) begin
          out_valid_r <= 1'b1;
          out_axis_r  <= ch_r ^ mode_r[MODE_SWAP];
          out_coord_r <= val;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_low_x_r    <= RAW_W'(200);
      raw_high_x_r   <= RAW_W'(3900);
      raw_low_y_r    <= RAW_W'(200);
      raw_high_y_r   <= RAW_W'(3900);
      screen_max_x_r <= COORD_W'(240);
      screen_max_y_r <= COORD_W'(320);
      mode_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RAW_LOW_X:    raw_low_x_r    <= cfg_data[RAW_W-1:0];
        REG_RAW_HIGH_X:   raw_high_x_r   <= cfg_data[RAW_W-1:0];
        REG_RAW_LOW_Y:    raw_low_y_r    <= cfg_data[RAW_W-1:0];
        REG_RAW_HIGH_Y:   raw_high_y_r   <= cfg_data[RAW_W-1:0];
        REG_SCREEN_MAX_X: screen_max_x_r <= cfg_data[COORD_W-1:0];
        REG_SCREEN_MAX_Y: screen_max_y_r <= cfg_data[COORD_W-1:0];
        REG_MODE_FLAGS:   mode_r         <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_axis       = out_axis_r;
  assign out_coordinate = out_coord_r;

`ifndef NO_ASSERTIONS
  a_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");
  a_pend_at_fin : assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != $past(pend_r)) |-> ($past(state_r) == S_FIN && $past(pair_mode)))
    else $error("pair state changed outside the finish step");
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_coord_r)))
    else $error("held result overwritten");
`endif

endmodule
